[rtl/core/sip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_pkg
// Types and constants shared by the SipHash MAC datapath and sequencer.
// ----------------------------------------------------------------------------
package sip_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned LEN_W      = 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned FINAL_ROUNDS = 4;

    localparam logic [WORD_W-1:0] INIT_C0 = 64'h736F6D6570736575;
    localparam logic [WORD_W-1:0] INIT_C1 = 64'h646F72616E646F6D;
    localparam logic [WORD_W-1:0] INIT_C2 = 64'h6C7967656E657261;
    localparam logic [WORD_W-1:0] INIT_C3 = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] FIN_XOR = 64'h00000000000000FF;

    localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] v2;
        logic [WORD_W-1:0] v3;
    } t_sip_state;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMP,
        ST_FIN
    } t_seq_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_stat;

endpackage

[rtl/core/siphash_2_4_mac_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siphash_2_4_mac_unit
// Keyed SipHash-2-4 MAC over a stream of little-endian 64-bit words.
// ----------------------------------------------------------------------------
// One SipRound unit runs one round per cycle. An accepted word is XORed into
// v3 and then runs COMPRESSION_ROUNDS rounds in ST_COMP; a last word goes on
// to the finalization rounds in ST_FIN, and a full last word is first followed
// by a length-only block that is also compressed. o_stall is high while a
// word is in the round loop. The digest sits in an output register, so the
// next message can start while it waits; finalization holds on its last
// round only if that register is still full. Keys load into the chaining
// words at the first word of each message and may be rewritten at any time.
// ----------------------------------------------------------------------------
module siphash_2_4_mac_unit #(
    parameter int unsigned COMPRESSION_ROUNDS = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [sip_pkg::WORD_W-1:0]      i_message_word,
    input  logic [sip_pkg::COUNT_W-1:0]     i_byte_count,
    input  logic                            i_last_word,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [sip_pkg::WORD_W-1:0]      o_digest,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sip_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sip_pkg::WORD_W-1:0]      i_cfg_data
);
    import sip_pkg::*;

    logic [WORD_W-1:0] r_key_low, r_key_high;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_digest;
    logic              accept;
    logic              out_free;
    t_core_stat        stat;
    logic [WORD_W-1:0] core_digest;

    assign accept      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;
    assign o_stall     = stat.busy;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_digest    = r_digest;

    sip_core #(
        .COMPRESSION_ROUNDS (COMPRESSION_ROUNDS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_word     (i_message_word),
        .i_count    (i_byte_count),
        .i_last     (i_last_word),
        .i_key_low  (r_key_low),
        .i_key_high (r_key_high),
        .i_out_free (out_free),
        .o_stat     (stat),
        .o_digest   (core_digest)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stat.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stat.done) begin
            r_digest <= core_digest;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !stat.done)
        else $error("digest beat overwritten while stalled");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.done |-> !accept)
        else $error("word accepted during finalization");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.done |=> (r_out_valid && r_digest == $past(core_digest)))
        else $error("digest beat not loaded");

endmodule

[rtl/core/sip_round.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_round
// One SipRound on the four chaining words, shared by compression and
// finalization.
// ----------------------------------------------------------------------------
module sip_round (
    input  sip_pkg::t_sip_state i_v,
    output sip_pkg::t_sip_state o_v
);
    import sip_pkg::*;

    logic [WORD_W-1:0] a0, b0, c0, d0;
    logic [WORD_W-1:0] b1, d1, a1, c1;
    logic [WORD_W-1:0] a2, b2, c2, d2;

    always_comb begin
        a0 = i_v.v0 + i_v.v1;
        b0 = {i_v.v1[50:0], i_v.v1[63:51]} ^ a0;
        a1 = {a0[31:0], a0[63:32]};
        c0 = i_v.v2 + i_v.v3;
        d0 = {i_v.v3[47:0], i_v.v3[63:48]} ^ c0;
        c1 = c0 + b0;
        b1 = {b0[46:0], b0[63:47]} ^ c1;
        c2 = {c1[31:0], c1[63:32]};
        a2 = a1 + d0;
        d1 = {d0[42:0], d0[63:43]} ^ a2;
        b2 = b1;
        d2 = d1;
        o_v.v0 = a2;
        o_v.v1 = b2;
        o_v.v2 = c2;
        o_v.v3 = d2;
    end

endmodule

[rtl/core/sip_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sip_core
// Chaining state, length count and round sequencer around one shared
// SipRound unit.
// ----------------------------------------------------------------------------
module sip_core #(
    parameter int unsigned COMPRESSION_ROUNDS = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [sip_pkg::WORD_W-1:0]    i_word,
    input  logic [sip_pkg::COUNT_W-1:0]   i_count,
    input  logic                          i_last,
    input  logic [sip_pkg::WORD_W-1:0]    i_key_low,
    input  logic [sip_pkg::WORD_W-1:0]    i_key_high,
    input  logic                          i_out_free,
    output sip_pkg::t_core_stat           o_stat,
    output logic [sip_pkg::WORD_W-1:0]    o_digest
);
    import sip_pkg::*;

    localparam int unsigned MAX_RND = (COMPRESSION_ROUNDS > FINAL_ROUNDS) ?
                                      COMPRESSION_ROUNDS : FINAL_ROUNDS;
    localparam int unsigned CNT_W   = (MAX_RND > 1) ? $clog2(MAX_RND) : 1;
    localparam logic [CNT_W-1:0] COMP_LOAD = CNT_W'(COMPRESSION_ROUNDS - 1);
    localparam logic [CNT_W-1:0] FIN_LOAD  = CNT_W'(FINAL_ROUNDS - 1);

    t_seq_state        r_state, n_state;
    t_sip_state        r_v, n_v;
    t_sip_state        rnd_v;
    t_sip_state        init_v, base_v;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [WORD_W-1:0] r_m, n_m;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_last, n_last;
    logic              r_tail_pend, n_tail_pend;
    logic              r_open, n_open;
    logic              done;
    logic [COUNT_W-1:0] sat_count;
    logic               full;
    logic [LEN_W-1:0]   len_base, len_new;
    logic [WORD_W-1:0]  masked, blk, tail_blk;

    sip_round u_round (
        .i_v (r_v),
        .o_v (rnd_v)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_tail_pend <= 1'b0;
            r_open      <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_tail_pend <= n_tail_pend;
            r_open      <= n_open;
            r_last      <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_m   <= n_m;
        r_len <= n_len;
    end

    always_comb begin
        init_v.v0 = i_key_low  ^ INIT_C0;
        init_v.v1 = i_key_high ^ INIT_C1;
        init_v.v2 = i_key_low  ^ INIT_C2;
        init_v.v3 = i_key_high ^ INIT_C3;
        base_v    = r_open ? r_v : init_v;
        len_base  = r_open ? r_len : '0;

        sat_count = (i_count > FULL_COUNT) ? FULL_COUNT : i_count;
        full      = (sat_count == FULL_COUNT);
        len_new   = len_base + (i_last ? LEN_W'(sat_count) : LEN_W'(FULL_COUNT));
        for (int b = 0; b < 8; b++) begin
            masked[8*b +: 8] = (COUNT_W'(b) < sat_count) ? i_word[8*b +: 8] : 8'h00;
        end
        blk      = (!i_last || full) ? i_word
                                     : (masked | {len_new, {(WORD_W-LEN_W){1'b0}}});
        tail_blk = {r_len, {(WORD_W-LEN_W){1'b0}}};

        n_state     = r_state;
        n_v         = r_v;
        n_cnt       = r_cnt;
        n_m         = r_m;
        n_len       = r_len;
        n_last      = r_last;
        n_tail_pend = r_tail_pend;
        n_open      = r_open;
        done        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_v         = base_v;
                    n_v.v3      = base_v.v3 ^ blk;
                    n_m         = blk;
                    n_len       = len_new;
                    n_last      = i_last;
                    n_tail_pend = i_last && full;
                    n_open      = 1'b1;
                    n_cnt       = COMP_LOAD;
                    n_state     = ST_COMP;
                end
            end
            ST_COMP: begin
                n_v = rnd_v;
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_v.v0 = rnd_v.v0 ^ r_m;
                    if (r_tail_pend) begin
                        n_v.v3      = rnd_v.v3 ^ tail_blk;
                        n_m         = tail_blk;
                        n_tail_pend = 1'b0;
                        n_cnt       = COMP_LOAD;
                    end else if (r_last) begin
                        n_v.v2  = rnd_v.v2 ^ FIN_XOR;
                        n_cnt   = FIN_LOAD;
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (r_cnt != '0) begin
                    n_v   = rnd_v;
                    n_cnt = r_cnt - 1'b1;
                end else if (i_out_free) begin
                    n_v     = rnd_v;
                    done    = 1'b1;
                    n_open  = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stat.busy = (r_state != ST_IDLE);
    assign o_stat.done = done;
    assign o_digest    = rnd_v.v0 ^ rnd_v.v1 ^ rnd_v.v2 ^ rnd_v.v3;

    a_done_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (!r_open && r_state == ST_IDLE))
        else $error("digest beat did not close the message");

    a_hold_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_cnt == '0 && !i_out_free)
        |=> (r_state == ST_FIN && $stable(r_v)))
        else $error("finalization advanced while output was busy");

    a_start_comp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_accept) |=> (r_state == ST_COMP && r_cnt == COMP_LOAD && r_open))
        else $error("accepted beat did not start compression");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_tail_pend)
        else $error("length block left pending in idle");

endmodule

[tb/siphash_2_4_mac_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siphash_2_4_mac_unit_tb
// Self-checking bench for the SipHash-2-4 MAC unit. A driver process feeds
// message beats from a queue and tracks its own chaining state to compute the
// digest of every finished message. A monitor process compares each digest
// beat against the oldest expected tag. Phases vary the key and the amount of
// sender idling and receiver stalling. One phase holds the receiver off long
// enough to back the unit up. Another rewrites the key in the middle of an
// open message.
// ----------------------------------------------------------------------------
module siphash_2_4_mac_unit_tb;

    localparam int unsigned W              = sip_pkg::WORD_W;
    localparam int unsigned CW             = sip_pkg::COUNT_W;
    localparam int          HALF_PERIOD    = 6;
    localparam int          RESET_CYCLES   = 9;
    localparam int          COMP_ROUNDS    = 2;
    localparam int          FIN_ROUNDS     = 4;
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          HOLD_CYCLES    = 600;
    localparam int          WATCHDOG_LIMIT = 4000;

    localparam logic [W-1:0] IV0     = 64'h736F6D6570736575;
    localparam logic [W-1:0] IV1     = 64'h646F72616E646F6D;
    localparam logic [W-1:0] IV2     = 64'h6C7967656E657261;
    localparam logic [W-1:0] IV3     = 64'h7465646279746573;
    localparam logic [W-1:0] FIN_XOR = 64'h00000000000000FF;

    typedef struct packed {
        logic [W-1:0]  word;
        logic [CW-1:0] count;
        logic          last;
    } t_msg_beat;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid   = 1'b0;
    logic [W-1:0]                  in_word    = '0;
    logic [CW-1:0]                 in_count   = '0;
    logic                          in_last    = 1'b0;
    logic                          in_stall;
    logic                          out_valid;
    logic                          out_stall  = 1'b0;
    logic [W-1:0]                  out_digest;
    logic                          cfg_valid  = 1'b0;
    logic                          cfg_ready;
    logic [sip_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
    logic [W-1:0]                  cfg_data   = '0;

    t_msg_beat            pending_q[$];
    logic [W-1:0]         digest_q[$];
    t_msg_beat            cur_beat;
    sip_pkg::t_sip_state  chain;
    logic [7:0]           msg_len     = '0;
    logic                 msg_open    = 1'b0;
    logic [W-1:0]         key_lo      = '0;
    logic [W-1:0]         key_hi      = '0;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    logic                 hold_armed  = 1'b0;
    int                   hold_cycles = 0;
    int                   quiet_cycles = 0;
    int                   mismatch_count = 0;
    int                   beats_made = 0;

    siphash_2_4_mac_unit u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_message_word (in_word),
        .i_byte_count   (in_count),
        .i_last_word    (in_last),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_digest       (out_digest),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic logic [W-1:0] rotl64(input logic [W-1:0] x, input int s);
        return (x << s) | (x >> (64 - s));
    endfunction

    function automatic sip_pkg::t_sip_state sip_round(input sip_pkg::t_sip_state s);
        logic [W-1:0] a, b, c, d;
        a = s.v0; b = s.v1; c = s.v2; d = s.v3;
        a = a + b; b = rotl64(b, 13); b = b ^ a; a = rotl64(a, 32);
        c = c + d; d = rotl64(d, 16); d = d ^ c;
        c = c + b; b = rotl64(b, 17); b = b ^ c; c = rotl64(c, 32);
        a = a + d; d = rotl64(d, 21); d = d ^ a;
        s.v0 = a; s.v1 = b; s.v2 = c; s.v3 = d;
        return s;
    endfunction

    function automatic sip_pkg::t_sip_state absorb_block(input sip_pkg::t_sip_state s,
                                                         input logic [W-1:0] m);
        s.v3 = s.v3 ^ m;
        for (int r = 0; r < COMP_ROUNDS; r++) s = sip_round(s);
        s.v0 = s.v0 ^ m;
        return s;
    endfunction

    function automatic logic [W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Advance the chaining state by one accepted beat; queue the tag on the last one.
    task automatic track_word(input t_msg_beat b);
        logic [CW-1:0] n;
        logic [W-1:0]  tail;
        if (!msg_open) begin
            chain.v0 = key_lo ^ IV0;
            chain.v1 = key_hi ^ IV1;
            chain.v2 = key_lo ^ IV2;
            chain.v3 = key_hi ^ IV3;
            msg_len  = '0;
            msg_open = 1'b1;
        end
        if (!b.last) begin
            chain   = absorb_block(chain, b.word);
            msg_len = msg_len + 8'd8;
        end else begin
            n       = (b.count > 4'd8) ? 4'd8 : b.count;
            msg_len = msg_len + {4'd0, n};
            tail    = '0;
            if (n == 4'd8) begin
                chain = absorb_block(chain, b.word);
            end else begin
                for (int k = 0; k < 8; k++)
                    if (k < n) tail[8*k +: 8] = b.word[8*k +: 8];
            end
            tail[63:56] = msg_len;
            chain    = absorb_block(chain, tail);
            chain.v2 = chain.v2 ^ FIN_XOR;
            for (int r = 0; r < FIN_ROUNDS; r++) chain = sip_round(chain);
            digest_q.push_back(chain.v0 ^ chain.v1 ^ chain.v2 ^ chain.v3);
            msg_open = 1'b0;
        end
    endtask

    task automatic push_beat(input logic [W-1:0] word, input logic [CW-1:0] count,
                             input logic last);
        t_msg_beat b;
        b.word  = word;
        b.count = count;
        b.last  = last;
        pending_q.push_back(b);
        beats_made++;
    endtask

    // Mostly short messages, a few long enough to wrap the length byte.
    task automatic add_message();
        int body;
        logic [CW-1:0] cnt;
        body = ($urandom_range(99) < 4) ? $urandom_range(40, 31) : $urandom_range(4, 0);
        for (int i = 0; i < body; i++) begin
            cnt = ($urandom_range(9) == 0) ? CW'($urandom_range(15)) : sip_pkg::FULL_COUNT;
            push_beat(rand_word(), cnt, 1'b0);
        end
        cnt = ($urandom_range(9) == 0) ? CW'($urandom_range(15, 9)) : CW'($urandom_range(8));
        push_beat(rand_word(), cnt, 1'b1);
    endtask

    task automatic add_messages(input int beat_target);
        int goal;
        goal = beats_made + beat_target;
        while (beats_made < goal) add_message();
    endtask

    task automatic write_key(input logic [sip_pkg::CFG_IDX_W-1:0] idx,
                             input logic [W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == sip_pkg::REG_KEY_LOW) key_lo = val;
        else key_hi = val;
    endtask

    task automatic start_phase(input int send_pct, input int recv_pct);
        @(negedge clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Wait for every queued beat and expected tag, then let the round loop drain.
    task automatic settle();
        do @(negedge clk);
        while (pending_q.size() != 0 || in_valid || digest_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk) begin : driver
        t_msg_beat nxt;
        logic      valid_n;
        valid_n = in_valid;
        if (!rst_n) begin
            valid_n = 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                track_word(cur_beat);
                valid_n = 1'b0;
            end
            if (!valid_n && pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt      = pending_q.pop_front();
                cur_beat = nxt;
                in_word  <= nxt.word;
                in_count <= nxt.count;
                in_last  <= nxt.last;
                valid_n  = 1'b1;
            end
        end
        in_valid <= valid_n;
    end

    always @(posedge clk) begin : monitor
        logic [W-1:0] exp_digest;
        logic         stall_n;
        if (rst_n && out_valid && !out_stall) begin
            if (digest_q.size() == 0) begin
                $display("%0t unexpected digest beat: expected none, actual %h",
                         $time, out_digest);
                mismatch_count++;
            end else begin
                exp_digest = digest_q.pop_front();
                if (out_digest !== exp_digest) begin
                    $display("%0t digest mismatch: expected %h, actual %h",
                             $time, exp_digest, out_digest);
                    mismatch_count++;
                end
            end
        end
        if (hold_armed && hold_cycles < HOLD_CYCLES) begin
            stall_n = 1'b1;
            hold_cycles++;
        end else begin
            stall_n = ($urandom_range(99) < recv_stall_pct);
        end
        out_stall <= stall_n;
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset key, corner beats
        start_phase(0, 0);
        push_beat('1, 4'd0, 1'b1);
        push_beat('1, 4'd1, 1'b1);
        push_beat('1, 4'd7, 1'b1);
        push_beat('1, 4'd8, 1'b1);
        push_beat('0, 4'd9, 1'b1);
        push_beat('1, 4'd15, 1'b1);
        push_beat('0, 4'd0, 1'b0);
        push_beat('1, 4'd15, 1'b0);
        push_beat(rand_word(), 4'd8, 1'b0);
        push_beat(rand_word(), 4'd4, 1'b1);
        push_beat(64'h0706050403020100, 4'd8, 1'b0);
        push_beat(64'h0F0E0D0C0B0A0908, 4'd0, 1'b1);
        push_beat(rand_word(), 4'd8, 1'b0);
        push_beat(rand_word(), 4'd8, 1'b1);
        settle();

        write_key(sip_pkg::REG_KEY_LOW, 64'h0706050403020100);
        write_key(sip_pkg::REG_KEY_HIGH, 64'h0F0E0D0C0B0A0908);
        start_phase(67, 0);
        push_beat('0, 4'd0, 1'b1);
        add_messages(350);
        settle();

        write_key(sip_pkg::REG_KEY_LOW, '1);
        write_key(sip_pkg::REG_KEY_HIGH, '1);
        start_phase(0, 67);
        add_messages(350);
        // leave a message open across the next key write
        for (int i = 0; i < 3; i++) push_beat(rand_word(), sip_pkg::FULL_COUNT, 1'b0);
        settle();

        write_key(sip_pkg::REG_KEY_LOW, '0);
        write_key(sip_pkg::REG_KEY_HIGH, rand_word());
        start_phase(7, 7);
        push_beat(rand_word(), CW'($urandom_range(8)), 1'b1);
        add_messages(350);
        settle();

        // hold the receiver off while short messages keep coming
        start_phase(0, 0);
        hold_armed = 1'b1;
        for (int i = 0; i < 150; i++) push_beat(rand_word(), CW'($urandom_range(15)), 1'b1);
        settle();

        write_key(sip_pkg::REG_KEY_LOW, rand_word());
        write_key(sip_pkg::REG_KEY_HIGH, rand_word());
        start_phase(0, 0);
        add_messages(530);
        settle();

        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
